>>> rtl/wsic_pkg.sv
`default_nettype none

package wsic_pkg;

    localparam logic [7:0] ID_RSN            = 8'h30;
    localparam logic [7:0] ID_VENDOR         = 8'hdd;
    localparam logic [7:0] WPA_OUI_TYPE      = 8'h01;
    localparam logic [7:0] RSN_MIN_PARSE_LEN = 8'd14;
    localparam logic [7:0] WPA_MIN_PARSE_LEN = 8'd17;
    localparam logic [7:0] AKM_TYPE_RESET    = 8'h01;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_WPA  = 2'd1;
    localparam logic [1:0] KIND_WPA2 = 2'd2;

    typedef struct packed {
        logic [7:0]  ie_byte;
        logic [15:0] buffer_length;
        logic        last;
    } item_t;

    typedef struct packed {
        logic [1:0] security_kind;
        logic       enterprise;
    } result_t;

    function automatic logic [7:0] wpa_vendor_byte(input logic [1:0] idx);
        logic [7:0] val;
        case (idx)
            2'd0:    val = 8'h00;
            2'd1:    val = 8'h50;
            2'd2:    val = 8'hf2;
            default: val = WPA_OUI_TYPE;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

>>> rtl/wsic_if.sv
`default_nettype none

interface wsic_item_if;
    logic        valid;
    logic        ready;
    logic [7:0]  ie_byte;
    logic [15:0] buffer_length;
    logic        last;

    modport source (output valid, output ie_byte, output buffer_length, output last,
                    input ready);
    modport sink   (input valid, input ie_byte, input buffer_length, input last,
                    output ready);
endinterface

interface wsic_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] security_kind;
    logic       enterprise;

    modport source (output valid, output security_kind, output enterprise, input ready);
    modport sink   (input valid, input security_kind, input enterprise, output ready);
endinterface

`default_nettype wire

>>> rtl/wifi_security_ie_classifier.sv
// Security classifier for one 802.11 information-element buffer.
// ie_item (sink): one buffer byte per item with buffer_length and last.
//   Elements are walked by id and length; the first RSN element or WPA
//   vendor element sets the kind, and the AKM suites of long enough
//   elements are scanned for the enterprise selector.
// result (source): one item per buffer, issued for the byte marked last,
//   carrying security_kind and enterprise.
// cfg_we / cfg_wdata: write the enterprise AKM type byte (reset 1);
//   write only while no buffer is in flight.
// Throughput: one byte per cycle, set by the single parser step between
//   the input register and the result register, unless a last byte stalls.
// A last byte is loaded from the input register into the result register.
// Stall: while the result register holds an untaken result, bytes keep
//   flowing until the next last byte, which waits in the input register;
//   ie_item.ready then drops.
// Reset: asynchronous, active low; clears the valid bits of both stages
//   and the parse state, and sets the AKM type back to 1.
`default_nettype none

module wifi_security_ie_classifier
    import wsic_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    wsic_item_if.sink       ie_item,
    wsic_result_if.source   result,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata
);

    logic    held_valid;
    item_t   held_item;
    logic    room;
    logic    advance;
    result_t step_result;

    assign advance = held_valid && (!held_item.last || room);

    wsic_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .ie_item    (ie_item),
        .take       (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    wsic_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .item      (held_item),
        .result    (step_result)
    );

    wsic_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && held_item.last),
        .result_in (step_result),
        .room      (room),
        .result    (result)
    );

endmodule

`default_nettype wire

>>> rtl/wsic_in_stage.sv
`default_nettype none

module wsic_in_stage
    import wsic_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    wsic_item_if.sink    ie_item,
    input  wire logic    take,
    output logic         held_valid,
    output item_t        held_item
);

    logic  valid_reg;
    item_t item_reg;

    assign ie_item.ready = !valid_reg || take;
    assign held_valid    = valid_reg;
    assign held_item     = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ie_item.ready)
        begin
            valid_reg <= ie_item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ie_item.valid && ie_item.ready)
        begin
            item_reg.ie_byte       <= ie_item.ie_byte;
            item_reg.buffer_length <= ie_item.buffer_length;
            item_reg.last          <= ie_item.last;
        end
    end

endmodule

`default_nettype wire

>>> rtl/wsic_parser.sv
`default_nettype none

module wsic_parser
    import wsic_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata,
    input  wire logic       advance,
    input  wire item_t      item,
    output result_t         result
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_LEN,
        PH_SKIP,
        PH_VENDOR,
        PH_FIXED,
        PH_PW_LO,
        PH_PW_HI,
        PH_PW_SKIP,
        PH_AKM_LO,
        PH_AKM_HI,
        PH_AKM_SCAN,
        PH_DONE
    } phase_t;

    logic [7:0]  akm_type_reg;
    logic [15:0] pos_reg,   pos_next;
    logic [16:0] nes_reg,   nes_next;
    logic [7:0]  id_reg,    id_next;
    logic [7:0]  len_reg,   len_next;
    phase_t      phase_reg, phase_next;
    logic [2:0]  fc_reg,    fc_next;
    logic [15:0] count_reg, count_next;
    logic        oui_reg,   oui_next;
    logic [1:0]  kind_reg,  kind_next;
    logic        ent_reg,   ent_next;

    phase_t      phase_step;
    logic [16:0] nes_step;
    logic [7:0]  id_step;
    logic [7:0]  len_step;
    logic [2:0]  fc_step;
    logic [15:0] count_step;
    logic        oui_step;
    logic [1:0]  kind_step;
    logic        ent_step;
    logic [16:0] pos_ext;
    logic [16:0] blen_ext;
    logic [7:0]  b;

    assign b        = item.ie_byte;
    assign pos_ext  = {1'b0, pos_reg};
    assign blen_ext = {1'b0, item.buffer_length};

    always_comb
    begin
        phase_step = phase_reg;
        nes_step   = nes_reg;
        id_step    = id_reg;
        len_step   = len_reg;
        fc_step    = fc_reg;
        count_step = count_reg;
        oui_step   = oui_reg;
        kind_step  = kind_reg;
        ent_step   = ent_reg;

        if (pos_reg < item.buffer_length && phase_reg != PH_DONE)
        begin
            if (phase_reg != PH_LEN && pos_ext == nes_reg)
            begin
                if (pos_ext + 17'd3 > blen_ext)
                begin
                    phase_step = PH_DONE;
                end
                else
                begin
                    id_step = b;
                    if (b == ID_RSN && kind_reg == KIND_NONE)
                    begin
                        kind_step = KIND_WPA2;
                    end
                    phase_step = PH_LEN;
                end
            end
            else if (phase_reg == PH_LEN)
            begin
                len_step = b;
                nes_step = pos_ext + 17'd1 + {9'd0, b};
                fc_step  = 3'd0;
                oui_step = 1'b1;
                if (id_reg == ID_RSN)
                begin
                    phase_step = (b > RSN_MIN_PARSE_LEN) ? PH_FIXED : PH_SKIP;
                end
                else if (id_reg == ID_VENDOR)
                begin
                    phase_step = PH_VENDOR;
                end
                else
                begin
                    phase_step = PH_SKIP;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_VENDOR:
                    begin
                        if (b != wpa_vendor_byte(fc_reg[1:0]))
                        begin
                            oui_step = 1'b0;
                        end
                        fc_step = fc_reg + 3'd1;
                        if (fc_reg[1:0] == 2'd3)
                        begin
                            fc_step = 3'd0;
                            if (oui_step)
                            begin
                                if (kind_reg == KIND_NONE)
                                begin
                                    kind_step = KIND_WPA;
                                end
                                phase_step = (len_reg > WPA_MIN_PARSE_LEN) ? PH_FIXED
                                                                           : PH_SKIP;
                            end
                            else
                            begin
                                phase_step = PH_SKIP;
                            end
                        end
                    end
                    PH_FIXED:
                    begin
                        fc_step = fc_reg + 3'd1;
                        if (fc_step >= 3'd6)
                        begin
                            fc_step    = 3'd0;
                            phase_step = PH_PW_LO;
                        end
                    end
                    PH_PW_LO, PH_AKM_LO:
                    begin
                        count_step = {8'd0, b};
                        phase_step = (phase_reg == PH_PW_LO) ? PH_PW_HI : PH_AKM_HI;
                    end
                    PH_PW_HI:
                    begin
                        count_step = {b, count_reg[7:0]};
                        fc_step    = 3'd0;
                        phase_step = (count_step != 16'd0) ? PH_PW_SKIP : PH_AKM_LO;
                    end
                    PH_PW_SKIP:
                    begin
                        fc_step = fc_reg + 3'd1;
                        if (fc_step >= 3'd4)
                        begin
                            fc_step    = 3'd0;
                            count_step = count_reg - 16'd1;
                            if (count_step == 16'd0)
                            begin
                                phase_step = PH_AKM_LO;
                            end
                        end
                    end
                    PH_AKM_HI:
                    begin
                        count_step = {b, count_reg[7:0]};
                        fc_step    = 3'd0;
                        phase_step = (count_step != 16'd0) ? PH_AKM_SCAN : PH_SKIP;
                    end
                    PH_AKM_SCAN:
                    begin
                        if (fc_reg >= 3'd3)
                        begin
                            fc_step = 3'd0;
                            if (b == akm_type_reg)
                            begin
                                ent_step   = 1'b1;
                                phase_step = PH_SKIP;
                            end
                            else
                            begin
                                count_step = count_reg - 16'd1;
                                if (count_step == 16'd0)
                                begin
                                    phase_step = PH_SKIP;
                                end
                            end
                        end
                        else
                        begin
                            fc_step = fc_reg + 3'd1;
                        end
                    end
                    default:
                    begin
                        phase_step = phase_reg;
                    end
                endcase
            end
        end
    end

    assign result.security_kind = kind_step;
    assign result.enterprise    = ent_step && (kind_step != KIND_NONE);

    always_comb
    begin
        pos_next   = pos_reg;
        nes_next   = nes_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        phase_next = phase_reg;
        fc_next    = fc_reg;
        count_next = count_reg;
        oui_next   = oui_reg;
        kind_next  = kind_reg;
        ent_next   = ent_reg;
        if (advance)
        begin
            if (item.last)
            begin
                pos_next   = 16'd0;
                nes_next   = 17'd0;
                id_next    = 8'd0;
                len_next   = 8'd0;
                phase_next = PH_IDLE;
                fc_next    = 3'd0;
                count_next = 16'd0;
                oui_next   = 1'b1;
                kind_next  = KIND_NONE;
                ent_next   = 1'b0;
            end
            else
            begin
                pos_next   = (pos_reg != 16'hffff) ? pos_reg + 16'd1 : pos_reg;
                nes_next   = nes_step;
                id_next    = id_step;
                len_next   = len_step;
                phase_next = phase_step;
                fc_next    = fc_step;
                count_next = count_step;
                oui_next   = oui_step;
                kind_next  = kind_step;
                ent_next   = ent_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            akm_type_reg <= AKM_TYPE_RESET;
            pos_reg      <= 16'd0;
            nes_reg      <= 17'd0;
            id_reg       <= 8'd0;
            len_reg      <= 8'd0;
            phase_reg    <= PH_IDLE;
            fc_reg       <= 3'd0;
            count_reg    <= 16'd0;
            oui_reg      <= 1'b1;
            kind_reg     <= KIND_NONE;
            ent_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                akm_type_reg <= cfg_wdata;
            end
            pos_reg   <= pos_next;
            nes_reg   <= nes_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            phase_reg <= phase_next;
            fc_reg    <= fc_next;
            count_reg <= count_next;
            oui_reg   <= oui_next;
            kind_reg  <= kind_next;
            ent_reg   <= ent_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/wsic_out_stage.sv
`default_nettype none

module wsic_out_stage
    import wsic_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     load,
    input  wire result_t  result_in,
    output logic          room,
    wsic_result_if.source result
);

    logic    valid_reg;
    result_t result_reg;

    assign room                 = !valid_reg || result.ready;
    assign result.valid         = valid_reg;
    assign result.security_kind = result_reg.security_kind;
    assign result.enterprise    = result_reg.enterprise;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

endmodule

`default_nettype wire

>>> rtl/wsic_checker.sv
`default_nettype none

module wsic_checker
    import wsic_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] out_kind,
    input wire logic       out_enterprise
);

    ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_enterprise))
        else $error("result changed while stalled");

    ap_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_kind == KIND_NONE || out_kind == KIND_WPA || out_kind == KIND_WPA2)
        else $error("illegal security kind");

    ap_ent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_enterprise |-> out_kind != KIND_NONE)
        else $error("enterprise without a security kind");

    ap_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a stalled result");

endmodule

bind wifi_security_ie_classifier wsic_checker u_wsic_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (ie_item.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .out_kind       (result.security_kind),
    .out_enterprise (result.enterprise)
);

`default_nettype wire

>>> test/wifi_security_ie_classifier_test.sv
module wifi_security_ie_classifier_test;
    import wsic_pkg::*;

    localparam logic [23:0] WPA_OUI     = 24'h0050f2;
    localparam logic [23:0] RSN_OUI     = 24'h000fac;
    localparam logic [7:0]  CIPHER_TKIP = 8'h02;
    localparam logic [7:0]  CIPHER_CCMP = 8'h04;
    localparam logic [7:0]  ID_SSID     = 8'h00;
    localparam logic [7:0]  ID_EXT      = 8'hff;
    localparam int          NO_HIT      = 5;

    typedef enum logic [3:0] {
        W_IDLE, W_LEN, W_SKIP, W_VENDOR, W_FIXED, W_PW_LO, W_PW_HI,
        W_PW_SKIP, W_AKM_LO, W_AKM_HI, W_AKM_SCAN, W_DONE
    } walk_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [7:0] cfg_wdata;

    wsic_item_if   ie_bus();
    wsic_result_if res_bus();

    wifi_security_ie_classifier i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .ie_item   (ie_bus),
        .result    (res_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    item_t       ie_bytes_pending[$];
    result_t     verdicts_due[$];
    logic [7:0]  ie_buf[$];
    logic [7:0]  body[$];
    int          bytes_queued;
    int          mismatches;
    bit          steady;
    int          hold_asks;
    int          hold_seen;
    int          hold_left;

    // classifier copy
    logic [7:0]  akm_reg;
    logic [15:0] m_pos;
    logic [16:0] m_next;
    logic [7:0]  m_id;
    logic [7:0]  m_len;
    walk_t       m_phase;
    logic [15:0] m_cnt;
    logic [15:0] m_suites;
    logic        m_oui_ok;
    logic [1:0]  m_kind;
    logic        m_ent;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic clear_walk();
        m_pos    = '0;
        m_next   = '0;
        m_id     = '0;
        m_len    = '0;
        m_phase  = W_IDLE;
        m_cnt    = '0;
        m_suites = '0;
        m_oui_ok = 1'b1;
        m_kind   = KIND_NONE;
        m_ent    = 1'b0;
    endtask

    task automatic walk_content(input logic [7:0] b);
        logic [1:0] idx;
        logic [7:0] want;
        case (m_phase)
            W_VENDOR: begin
                idx  = m_cnt[1:0];
                want = (idx == 2'd3) ? WPA_OUI_TYPE : WPA_OUI[23 - 8 * idx -: 8];
                if (b != want)
                    m_oui_ok = 1'b0;
                m_cnt = m_cnt + 1'b1;
                if (idx == 2'd3) begin
                    m_cnt = '0;
                    if (m_oui_ok) begin
                        if (m_kind == KIND_NONE)
                            m_kind = KIND_WPA;
                        m_phase = (m_len > WPA_MIN_PARSE_LEN) ? W_FIXED : W_SKIP;
                    end
                    else
                        m_phase = W_SKIP;
                end
            end
            W_FIXED: begin
                m_cnt = m_cnt + 1'b1;
                if (m_cnt >= 16'd6) begin
                    m_cnt   = '0;
                    m_phase = W_PW_LO;
                end
            end
            W_PW_LO: begin
                m_suites = {8'h00, b};
                m_phase  = W_PW_HI;
            end
            W_PW_HI: begin
                m_suites = {b, m_suites[7:0]};
                m_cnt    = '0;
                m_phase  = (m_suites != '0) ? W_PW_SKIP : W_AKM_LO;
            end
            W_PW_SKIP: begin
                m_cnt = m_cnt + 1'b1;
                if (m_cnt >= 16'd4) begin
                    m_cnt    = '0;
                    m_suites = m_suites - 1'b1;
                    if (m_suites == '0)
                        m_phase = W_AKM_LO;
                end
            end
            W_AKM_LO: begin
                m_suites = {8'h00, b};
                m_phase  = W_AKM_HI;
            end
            W_AKM_HI: begin
                m_suites = {b, m_suites[7:0]};
                m_cnt    = '0;
                m_phase  = (m_suites != '0) ? W_AKM_SCAN : W_SKIP;
            end
            W_AKM_SCAN: begin
                if (m_cnt >= 16'd3) begin
                    m_cnt = '0;
                    if (b == akm_reg) begin
                        m_ent   = 1'b1;
                        m_phase = W_SKIP;
                    end
                    else begin
                        m_suites = m_suites - 1'b1;
                        if (m_suites == '0)
                            m_phase = W_SKIP;
                    end
                end
                else
                    m_cnt = m_cnt + 1'b1;
            end
            default: ;
        endcase
    endtask

    task automatic classify_byte(input item_t it);
        result_t verdict;
        if (m_pos < it.buffer_length && m_phase != W_DONE) begin
            if (m_phase != W_LEN && {1'b0, m_pos} == m_next) begin
                if ({1'b0, m_pos} + 17'd3 > {1'b0, it.buffer_length})
                    m_phase = W_DONE;
                else begin
                    m_id = it.ie_byte;
                    if (it.ie_byte == ID_RSN && m_kind == KIND_NONE)
                        m_kind = KIND_WPA2;
                    m_phase = W_LEN;
                end
            end
            else if (m_phase == W_LEN) begin
                m_len    = it.ie_byte;
                m_next   = {1'b0, m_pos} + 17'd1 + it.ie_byte;
                m_cnt    = '0;
                m_oui_ok = 1'b1;
                if (m_id == ID_RSN)
                    m_phase = (it.ie_byte > RSN_MIN_PARSE_LEN) ? W_FIXED : W_SKIP;
                else if (m_id == ID_VENDOR)
                    m_phase = W_VENDOR;
                else
                    m_phase = W_SKIP;
            end
            else
                walk_content(it.ie_byte);
        end
        if (m_pos != 16'hffff)
            m_pos = m_pos + 1'b1;
        if (it.last) begin
            verdict.security_kind = m_kind;
            verdict.enterprise    = m_ent && (m_kind != KIND_NONE);
            verdicts_due.push_back(verdict);
            clear_walk();
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // input side
    always @(posedge clk or negedge rst_n) begin
        item_t nxt;
        if (!rst_n) begin
            ie_bus.valid         <= 1'b0;
            ie_bus.ie_byte       <= '0;
            ie_bus.buffer_length <= '0;
            ie_bus.last          <= 1'b0;
        end
        else if (!ie_bus.valid || ie_bus.ready) begin
            if (ie_bytes_pending.size() != 0 && (steady || $urandom_range(99) >= 33)) begin
                nxt = ie_bytes_pending.pop_front();
                ie_bus.valid         <= 1'b1;
                ie_bus.ie_byte       <= nxt.ie_byte;
                ie_bus.buffer_length <= nxt.buffer_length;
                ie_bus.last          <= nxt.last;
            end
            else
                ie_bus.valid <= 1'b0;
        end
    end

    // result side
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            res_bus.ready <= 1'b0;
            hold_left     <= 0;
            hold_seen     <= 0;
        end
        else if (hold_left > 0) begin
            res_bus.ready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (hold_seen != hold_asks) begin
            res_bus.ready <= 1'b0;
            hold_left     <= 300;
            hold_seen     <= hold_asks;
        end
        else
            res_bus.ready <= steady || ($urandom_range(99) >= 33);
    end

    always @(posedge clk) begin
        item_t   taken;
        result_t want;
        if (rst_n) begin
            if (ie_bus.valid && ie_bus.ready) begin
                taken.ie_byte       = ie_bus.ie_byte;
                taken.buffer_length = ie_bus.buffer_length;
                taken.last          = ie_bus.last;
                classify_byte(taken);
            end
            if (res_bus.valid && res_bus.ready) begin
                if (verdicts_due.size() == 0)
                    report_mismatch($sformatf("unexpected result kind %0d enterprise %0b",
                                              res_bus.security_kind, res_bus.enterprise));
                else begin
                    want = verdicts_due.pop_front();
                    if (res_bus.security_kind !== want.security_kind)
                        report_mismatch($sformatf("security_kind %0d, want %0d",
                                                  res_bus.security_kind, want.security_kind));
                    if (res_bus.enterprise !== want.enterprise)
                        report_mismatch($sformatf("enterprise %0b, want %0b",
                                                  res_bus.enterprise, want.enterprise));
                end
            end
        end
    end

    task automatic add_byte(input logic [7:0] b);
        body.push_back(b);
    endtask

    task automatic add_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            body.push_back(w[8 * i +: 8]);
    endtask

    task automatic trim_body(input int keep);
        while (body.size() > keep)
            void'(body.pop_back());
    endtask

    task automatic close_elem(input logic [7:0] id);
        ie_buf.push_back(id);
        ie_buf.push_back(8'(body.size()));
        foreach (body[i])
            ie_buf.push_back(body[i]);
        body.delete();
    endtask

    task automatic send_buf(input logic [15:0] blen);
        item_t it;
        foreach (ie_buf[i]) begin
            it.ie_byte       = ie_buf[i];
            it.buffer_length = blen;
            it.last          = (i == ie_buf.size() - 1);
            ie_bytes_pending.push_back(it);
        end
        bytes_queued += ie_buf.size();
        ie_buf.delete();
    endtask

    task automatic build_suites(input bit wpa, input int n_pw, input int n_akm,
                                input logic [15:0] pw_decl, input logic [15:0] akm_decl,
                                input int hit, input int tail);
        body.delete();
        if (wpa)
            add_word({WPA_OUI, WPA_OUI_TYPE});
        add_byte(8'h01);
        add_byte(8'h00);
        add_word(wpa ? {WPA_OUI, CIPHER_TKIP} : {RSN_OUI, CIPHER_CCMP});
        add_byte(pw_decl[7:0]);
        add_byte(pw_decl[15:8]);
        repeat (n_pw)
            add_word($urandom());
        add_byte(akm_decl[7:0]);
        add_byte(akm_decl[15:8]);
        for (int i = 0; i < n_akm; i++)
            add_word({wpa ? WPA_OUI : RSN_OUI, (i == hit) ? akm_reg : 8'($urandom())});
        repeat (tail)
            add_byte(8'($urandom()));
    endtask

    task automatic random_buffer();
        int          pick;
        int          n_pw;
        int          n_akm;
        bit          wpa;
        logic [15:0] pw_decl;
        logic [15:0] akm_decl;
        logic [15:0] blen;
        if ($urandom_range(19) == 0) begin
            repeat ($urandom_range(1, 3))
                ie_buf.push_back(8'($urandom()));
        end
        else begin
            repeat ($urandom_range(1, 3)) begin
                pick = $urandom_range(99);
                if (pick < 60) begin
                    wpa      = (pick >= 35);
                    n_pw     = $urandom_range(0, 3);
                    n_akm    = $urandom_range(0, 3);
                    pw_decl  = 16'(n_pw);
                    akm_decl = 16'(n_akm);
                    case ($urandom_range(9))
                        0: akm_decl = 16'(n_akm + $urandom_range(1, 3));
                        1: akm_decl = 16'($urandom());
                        2: pw_decl = 16'(n_pw + 1);
                        default: ;
                    endcase
                    build_suites(wpa, n_pw, n_akm, pw_decl, akm_decl,
                                 $urandom_range(0, 3), $urandom_range(0, 2));
                    if (wpa && $urandom_range(7) == 0)
                        body[$urandom_range(0, 3)] ^= 8'h01 << $urandom_range(0, 7);
                    if ($urandom_range(7) == 0)
                        trim_body($urandom_range(0, body.size()));
                    close_elem(wpa ? ID_VENDOR : ID_RSN);
                end
                else if (pick < 72) begin
                    // vendor element too short or with a wrong selector
                    add_word({WPA_OUI, WPA_OUI_TYPE});
                    if ($urandom_range(1))
                        body[$urandom_range(0, 3)] ^= 8'h01 << $urandom_range(0, 7);
                    trim_body($urandom_range(0, 4));
                    close_elem(ID_VENDOR);
                end
                else begin
                    repeat ($urandom_range(0, 12))
                        add_byte(8'($urandom()));
                    close_elem(8'($urandom()));
                end
            end
        end
        case ($urandom_range(9))
            0: blen = 16'($urandom_range(0, ie_buf.size()));
            1: blen = 16'($urandom_range(ie_buf.size(), 65535));
            default: blen = 16'(ie_buf.size());
        endcase
        send_buf(blen);
    endtask

    task automatic random_phase(input int n_bytes);
        int start;
        start = bytes_queued;
        while (bytes_queued - start < n_bytes)
            random_buffer();
    endtask

    task automatic wait_quiet();
        @(negedge clk);
        while (ie_bytes_pending.size() != 0 || ie_bus.valid || verdicts_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_enterprise_akm(input logic [7:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        akm_reg = v;
        @(negedge clk);
    endtask

    task automatic directed_buffers();
        // too short to start an element
        ie_buf.push_back(ID_RSN);
        send_buf(16'd1);
        ie_buf.push_back(ID_RSN);
        ie_buf.push_back(8'h00);
        send_buf(16'd2);
        // exactly three bytes left, then the walk ends
        ie_buf.push_back(ID_RSN);
        ie_buf.push_back(8'h00);
        ie_buf.push_back(ID_RSN);
        send_buf(16'd3);
        // vendor element too short for OUI and type, then one with just those
        add_word({WPA_OUI, WPA_OUI_TYPE});
        trim_body(3);
        close_elem(ID_VENDOR);
        send_buf(16'd5);
        add_word({WPA_OUI, WPA_OUI_TYPE});
        close_elem(ID_VENDOR);
        send_buf(16'd6);
        // RSN at the parse threshold and one above
        build_suites(1'b0, 0, 1, 16'd0, 16'd1, 0, 0);
        close_elem(ID_RSN);
        send_buf(16'(ie_buf.size()));
        build_suites(1'b0, 0, 1, 16'd0, 16'd1, 0, 1);
        close_elem(ID_RSN);
        send_buf(16'(ie_buf.size()));
        // WPA above and at the parse threshold
        build_suites(1'b1, 0, 1, 16'd0, 16'd1, 0, 0);
        close_elem(ID_VENDOR);
        send_buf(16'(ie_buf.size()));
        build_suites(1'b1, 0, 1, 16'd0, 16'd1, 0, 0);
        trim_body(17);
        close_elem(ID_VENDOR);
        send_buf(16'(ie_buf.size()));
        // WPA first, then RSN carrying the enterprise suite
        repeat (3) add_byte(8'($urandom()));
        close_elem(ID_SSID);
        build_suites(1'b1, 1, 2, 16'd1, 16'd2, NO_HIT, 2);
        close_elem(ID_VENDOR);
        build_suites(1'b0, 2, 1, 16'd2, 16'd1, 0, 2);
        close_elem(ID_RSN);
        send_buf(16'(ie_buf.size()));
        // AKM count runs past the element end into a lookalike
        build_suites(1'b0, 1, 1, 16'd1, 16'd3, NO_HIT, 0);
        close_elem(ID_RSN);
        repeat (2) add_word({RSN_OUI, akm_reg});
        close_elem(ID_SSID);
        send_buf(16'(ie_buf.size()));
        // buffer_length shorter than the bytes sent
        build_suites(1'b0, 1, 1, 16'd1, 16'd1, 0, 2);
        close_elem(ID_RSN);
        send_buf(16'd10);
        // buffer ends inside the element
        build_suites(1'b0, 1, 1, 16'd1, 16'd1, 0, 2);
        close_elem(ID_RSN);
        while (ie_buf.size() > 12)
            void'(ie_buf.pop_back());
        send_buf(16'hffff);
        // longest element, then a full RSN
        repeat (255) add_byte(8'($urandom()));
        close_elem(ID_EXT);
        build_suites(1'b0, 2, 2, 16'd2, 16'd2, 1, 2);
        close_elem(ID_RSN);
        send_buf(16'(ie_buf.size()));
        // wrong vendor type
        add_word({WPA_OUI, 8'h02});
        repeat (20) add_byte(8'($urandom()));
        close_elem(ID_VENDOR);
        send_buf(16'(ie_buf.size()));
        // empty AKM list
        build_suites(1'b0, 0, 0, 16'd0, 16'd0, NO_HIT, 2);
        close_elem(ID_RSN);
        send_buf(16'(ie_buf.size()));
    endtask

    initial begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        steady               = 1'b0;
        hold_asks            = 0;
        bytes_queued         = 0;
        mismatches           = 0;
        akm_reg              = AKM_TYPE_RESET;
        clear_walk();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed_buffers();
        random_phase(200);
        wait_quiet();

        set_enterprise_akm(8'h00);
        random_phase(200);
        @(posedge clk);
        hold_asks <= hold_asks + 1;
        wait_quiet();

        set_enterprise_akm(8'hff);
        @(posedge clk);
        steady <= 1'b1;
        @(negedge clk);
        random_phase(200);
        wait_quiet();
        @(posedge clk);
        steady <= 1'b0;

        set_enterprise_akm(8'($urandom()));
        random_phase(200);
        @(posedge clk);
        hold_asks <= hold_asks + 1;
        wait_quiet();

        set_enterprise_akm(8'h02);
        random_phase(150);
        wait_quiet();

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
